### design/rmh_pkg.sv
// ----------------------------------------------------------------------------
// rmh_pkg
// Shared constants, command/status types and helpers for the two-heap
// running median block.
// ----------------------------------------------------------------------------
package rmh_pkg;

    localparam int HEAP_DEPTH = 512;
    localparam int IDX_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int DATA_W     = 32;

    localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(HEAP_DEPTH);
    localparam logic [CNT_W:0]    TOTAL_CAP = (CNT_W+1)'(2 * HEAP_DEPTH);

    // heap select
    localparam logic SEL_LO = 1'b0;
    localparam logic SEL_UP = 1'b1;

    // datapath operations
    localparam logic [3:0] DP_NOP      = 4'd0;
    localparam logic [3:0] DP_LOAD     = 4'd1;
    localparam logic [3:0] DP_RD_ROOT  = 4'd2;
    localparam logic [3:0] DP_SET_PUSH = 4'd3;
    localparam logic [3:0] DP_UP_RD    = 4'd4;
    localparam logic [3:0] DP_UP_CMP   = 4'd5;
    localparam logic [3:0] DP_WR_VAL   = 4'd6;
    localparam logic [3:0] DP_SET_REPL = 4'd7;
    localparam logic [3:0] DP_RD_LAST  = 4'd8;
    localparam logic [3:0] DP_SET_POP  = 4'd9;
    localparam logic [3:0] DP_DN_RDL   = 4'd10;
    localparam logic [3:0] DP_DN_RDR   = 4'd11;
    localparam logic [3:0] DP_DN_CMP   = 4'd12;
    localparam logic [3:0] DP_MED      = 4'd13;

    typedef struct packed {
        logic [3:0] op;
        logic       sel;
        logic       src_moved;
    } dp_cmd_t;

    typedef struct packed {
        logic full_all;
        logic lo_empty;
        logic lo_full;
        logic up_full;
        logic key_lt_lo;
        logic key_lt_up;
        logic lo_heavy;
        logic up_heavy;
        logic idx_zero;
        logic up_stop;
        logic no_left;
        logic dn_stop;
        logic out_free;
    } dp_stat_t;

    // max-heap for the lower half, min-heap for the upper half
    function automatic logic outranks(input logic is_min,
                                      input logic [DATA_W-1:0] a,
                                      input logic [DATA_W-1:0] b);
        return is_min ? (a < b) : (a > b);
    endfunction

endpackage

### design/rmh_datapath.sv
// ----------------------------------------------------------------------------
// rmh_datapath
// Heap memories, counts, sift registers and the result register.
// ----------------------------------------------------------------------------
module rmh_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rmh_pkg::dp_cmd_t          cmd,
    output rmh_pkg::dp_stat_t         stat,
    input  logic signed [31:0]        s_sample_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [31:0]        m_median_value,
    output logic                      m_dropped
);
    import rmh_pkg::*;

    logic [DATA_W-1:0] lo_mem [HEAP_DEPTH];
    logic [DATA_W-1:0] up_mem [HEAP_DEPTH];

    logic [DATA_W-1:0] rd_lo_reg, rd_up_reg;
    logic [DATA_W-1:0] key_reg, val_reg, moved_reg, left_reg, med_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  n_reg, lcnt_reg, ucnt_reg;
    logic              hsel_reg, drop_reg, drop_out_reg, m_valid_reg;

    logic [DATA_W-1:0] rd_cur, cmd_rd, best_val, wdata;
    logic [CNT_W-1:0]  cmd_cnt;
    logic [CNT_W:0]    left_w, right_w;
    logic [IDX_W-1:0]  parent, best_idx, raddr;
    logic              has_right, take_r, wr_en;

    always_comb begin
        rd_cur    = hsel_reg ? rd_up_reg : rd_lo_reg;
        cmd_rd    = cmd.sel ? rd_up_reg : rd_lo_reg;
        cmd_cnt   = cmd.sel ? ucnt_reg : lcnt_reg;
        left_w    = (CNT_W+1)'({idx_reg, 1'b1});
        right_w   = left_w + 1'b1;
        parent    = IDX_W'((idx_reg - 1'b1) >> 1);
        has_right = right_w < {1'b0, n_reg};
        take_r    = has_right && outranks(hsel_reg, rd_cur, left_reg);
        best_val  = take_r ? rd_cur : left_reg;
        best_idx  = take_r ? IDX_W'(right_w) : IDX_W'(left_w);
    end

    always_comb begin
        stat.full_all  = ({1'b0, lcnt_reg} + {1'b0, ucnt_reg}) >= TOTAL_CAP;
        stat.lo_empty  = lcnt_reg == '0;
        stat.lo_full   = lcnt_reg == CNT_FULL;
        stat.up_full   = ucnt_reg == CNT_FULL;
        stat.key_lt_lo = key_reg < rd_lo_reg;
        stat.key_lt_up = key_reg < rd_up_reg;
        stat.lo_heavy  = {1'b0, lcnt_reg} > ({1'b0, ucnt_reg} + 1'b1);
        stat.up_heavy  = {1'b0, ucnt_reg} > ({1'b0, lcnt_reg} + 1'b1);
        stat.idx_zero  = idx_reg == '0;
        stat.up_stop   = !outranks(hsel_reg, val_reg, rd_cur);
        stat.no_left   = left_w >= {1'b0, n_reg};
        stat.dn_stop   = !outranks(hsel_reg, best_val, val_reg);
        stat.out_free  = !m_valid_reg || m_ready;
    end

    always_comb begin
        wr_en = 1'b0;
        wdata = val_reg;
        raddr = '0;
        unique case (cmd.op)
            DP_UP_RD:   raddr = parent;
            DP_DN_RDL:  raddr = IDX_W'(left_w);
            DP_DN_RDR:  raddr = IDX_W'(right_w);
            DP_RD_LAST: raddr = IDX_W'(cmd_cnt - 1'b1);
            DP_WR_VAL:  wr_en = 1'b1;
            DP_UP_CMP: begin
                wr_en = 1'b1;
                wdata = stat.up_stop ? val_reg : rd_cur;
            end
            DP_DN_CMP: begin
                wr_en = 1'b1;
                wdata = stat.dn_stop ? val_reg : best_val;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en && hsel_reg == SEL_LO) lo_mem[idx_reg] <= wdata;
        rd_lo_reg <= lo_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && hsel_reg == SEL_UP) up_mem[idx_reg] <= wdata;
        rd_up_reg <= up_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            DP_LOAD: begin
                key_reg  <= DATA_W'(s_sample_value) ^ SIGN_FLIP;
                drop_reg <= stat.full_all;
            end
            DP_SET_PUSH: begin
                hsel_reg <= cmd.sel;
                val_reg  <= cmd.src_moved ? moved_reg : key_reg;
                idx_reg  <= IDX_W'(cmd_cnt);
            end
            DP_UP_CMP:  if (!stat.up_stop) idx_reg <= parent;
            DP_SET_REPL: begin
                hsel_reg  <= cmd.sel;
                moved_reg <= cmd_rd;
                val_reg   <= key_reg;
                idx_reg   <= '0;
                n_reg     <= cmd_cnt;
            end
            DP_RD_LAST: moved_reg <= cmd_rd;
            DP_SET_POP: begin
                hsel_reg <= cmd.sel;
                val_reg  <= cmd_rd;
                idx_reg  <= '0;
                n_reg    <= cmd_cnt - 1'b1;
            end
            DP_DN_RDR:  left_reg <= rd_cur;
            DP_DN_CMP:  if (!stat.dn_stop) idx_reg <= best_idx;
            DP_MED: begin
                drop_out_reg <= drop_reg;
                if (lcnt_reg == '0 && ucnt_reg == '0) med_reg <= SIGN_FLIP;
                else if (lcnt_reg >= ucnt_reg)        med_reg <= rd_lo_reg;
                else                                  med_reg <= rd_up_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcnt_reg    <= '0;
            ucnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == DP_SET_PUSH) begin
                if (cmd.sel == SEL_UP) ucnt_reg <= ucnt_reg + 1'b1;
                else                   lcnt_reg <= lcnt_reg + 1'b1;
            end else if (cmd.op == DP_SET_POP) begin
                if (cmd.sel == SEL_UP) ucnt_reg <= ucnt_reg - 1'b1;
                else                   lcnt_reg <= lcnt_reg - 1'b1;
            end
            if (cmd.op == DP_MED)  m_valid_reg <= 1'b1;
            else if (m_ready)      m_valid_reg <= 1'b0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_median_value = signed'(med_reg ^ SIGN_FLIP);
    assign m_dropped      = drop_out_reg;

endmodule

### design/rmh_ctrl.sv
// ----------------------------------------------------------------------------
// rmh_ctrl
// Sequencer: insert decision, sift-up/sift-down loops, rebalance, result.
// ----------------------------------------------------------------------------
module rmh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output rmh_pkg::dp_cmd_t  cmd,
    input  rmh_pkg::dp_stat_t stat
);
    import rmh_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHK    = 4'd1;
    localparam logic [3:0] S_DEC    = 4'd2;
    localparam logic [3:0] S_UPRD   = 4'd3;
    localparam logic [3:0] S_UPCMP  = 4'd4;
    localparam logic [3:0] S_DNL    = 4'd5;
    localparam logic [3:0] S_DNR    = 4'd6;
    localparam logic [3:0] S_DNC    = 4'd7;
    localparam logic [3:0] S_BAL    = 4'd8;
    localparam logic [3:0] S_PLAST  = 4'd9;
    localparam logic [3:0] S_PSET   = 4'd10;
    localparam logic [3:0] S_PUSHMV = 4'd11;
    localparam logic [3:0] S_MRD    = 4'd12;
    localparam logic [3:0] S_MED    = 4'd13;

    localparam logic [1:0] R_BAL  = 2'd0;
    localparam logic [1:0] R_MED  = 2'd1;
    localparam logic [1:0] R_MVUP = 2'd2;
    localparam logic [1:0] R_MVLO = 2'd3;

    logic [3:0] state_reg, state_next, ret_state;
    logic [1:0] ret_reg, ret_next;
    logic       sel_reg, sel_next;

    always_comb begin
        unique case (ret_reg)
            R_BAL:   ret_state = S_BAL;
            R_MED:   ret_state = S_MRD;
            default: ret_state = S_PUSHMV;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        sel_next      = sel_reg;
        cmd.op        = DP_NOP;
        cmd.sel       = sel_reg;
        cmd.src_moved = 1'b0;
        unique case (state_reg)
            S_IDLE: if (s_valid) begin
                cmd.op     = DP_LOAD;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (stat.full_all) begin
                    state_next = S_MRD;
                end else begin
                    cmd.op     = DP_RD_ROOT;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                if (stat.lo_empty || stat.key_lt_lo) begin
                    cmd.sel = SEL_LO;
                    if (!stat.lo_full) begin
                        cmd.op     = DP_SET_PUSH;
                        ret_next   = R_BAL;
                        state_next = S_UPRD;
                    end else begin
                        cmd.op     = DP_SET_REPL;
                        ret_next   = R_MVUP;
                        state_next = S_DNL;
                    end
                end else if (!stat.up_full) begin
                    cmd.sel    = SEL_UP;
                    cmd.op     = DP_SET_PUSH;
                    ret_next   = R_BAL;
                    state_next = S_UPRD;
                end else if (stat.key_lt_up) begin
                    cmd.sel    = SEL_LO;
                    cmd.op     = DP_SET_PUSH;
                    ret_next   = R_MED;
                    state_next = S_UPRD;
                end else begin
                    cmd.sel    = SEL_UP;
                    cmd.op     = DP_SET_REPL;
                    ret_next   = R_MVLO;
                    state_next = S_DNL;
                end
            end
            S_UPRD: begin
                if (stat.idx_zero) begin
                    cmd.op     = DP_WR_VAL;
                    state_next = ret_state;
                end else begin
                    cmd.op     = DP_UP_RD;
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP: begin
                cmd.op     = DP_UP_CMP;
                state_next = stat.up_stop ? ret_state : S_UPRD;
            end
            S_DNL: begin
                if (stat.no_left) begin
                    cmd.op     = DP_WR_VAL;
                    state_next = ret_state;
                end else begin
                    cmd.op     = DP_DN_RDL;
                    state_next = S_DNR;
                end
            end
            S_DNR: begin
                cmd.op     = DP_DN_RDR;
                state_next = S_DNC;
            end
            S_DNC: begin
                cmd.op     = DP_DN_CMP;
                state_next = stat.dn_stop ? ret_state : S_DNL;
            end
            S_BAL: begin
                if (stat.lo_heavy) begin
                    cmd.op     = DP_RD_ROOT;
                    sel_next   = SEL_LO;
                    state_next = S_PLAST;
                end else if (stat.up_heavy) begin
                    cmd.op     = DP_RD_ROOT;
                    sel_next   = SEL_UP;
                    state_next = S_PLAST;
                end else begin
                    state_next = S_MRD;
                end
            end
            S_PLAST: begin
                cmd.op     = DP_RD_LAST;
                state_next = S_PSET;
            end
            S_PSET: begin
                cmd.op     = DP_SET_POP;
                ret_next   = (sel_reg == SEL_LO) ? R_MVUP : R_MVLO;
                state_next = S_DNL;
            end
            S_PUSHMV: begin
                cmd.op        = DP_SET_PUSH;
                cmd.sel       = (ret_reg == R_MVUP) ? SEL_UP : SEL_LO;
                cmd.src_moved = 1'b1;
                ret_next      = R_MED;
                state_next    = S_UPRD;
            end
            S_MRD: begin
                cmd.op     = DP_RD_ROOT;
                state_next = S_MED;
            end
            S_MED: if (stat.out_free) begin
                cmd.op     = DP_MED;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= R_MED;
            sel_reg   <= SEL_LO;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            sel_reg   <= sel_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;

endmodule

### design/running_median_two_heaps_core.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps_core
// Running median of signed samples held in a max-heap and a min-heap.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  sample  | s_valid s_ready s_sample_value     | in
//  median  | m_valid m_ready m_median_value     | out
//          | m_dropped                          |
//
// One transfer in, one transfer out. A dropped sample is not stored; a stored
// one is sifted up or down level by level, a rebalance or a full target heap
// adding a further sift. Each heap holds 512 entries and each heap memory has
// a single read port.
// Reset clears both counts; the heap memories need no clearing.
// A new sample is taken while the previous median waits in the output register.
// ----------------------------------------------------------------------------
module running_median_two_heaps_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_sample_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_median_value,
    output logic               m_dropped
);
    import rmh_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rmh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    rmh_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_sample_value (s_sample_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_median_value (m_median_value),
        .m_dropped      (m_dropped)
    );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-heap running median core. A queue-fed
// driver pushes signed samples, a monitor checks each median transfer
// against a behavioural two-heap predictor held in the bench.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmh_pkg::*;

    localparam int CAP = HEAP_DEPTH;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_sample_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_median_value;
    logic               m_dropped;

    running_median_two_heaps_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_median_value (m_median_value),
        .m_dropped      (m_dropped)
    );

    always #1 aclk = ~aclk;

    typedef struct packed {
        logic signed [31:0] median;
        logic               dropped;
    } median_t;

    logic signed [31:0] sample_q[$];
    median_t            median_q[$];
    int                 errors = 0;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    logic               in_fire = 1'b0;

    // predictor: heaps hold signed values directly
    logic signed [31:0] lo_h[CAP];
    logic signed [31:0] up_h[CAP];
    int                 lo_n = 0;
    int                 up_n = 0;

    function automatic bit beats(bit is_max, logic signed [31:0] a, logic signed [31:0] b);
        return is_max ? (a > b) : (a < b);
    endfunction

    task automatic heap_push(bit is_max, logic signed [31:0] v);
        int i, p;
        logic signed [31:0] t;
        if (is_max) begin
            i = lo_n; lo_h[i] = v; lo_n++;
            while (i > 0) begin
                p = (i - 1) / 2;
                if (!beats(1, lo_h[i], lo_h[p])) break;
                t = lo_h[i]; lo_h[i] = lo_h[p]; lo_h[p] = t; i = p;
            end
        end else begin
            i = up_n; up_h[i] = v; up_n++;
            while (i > 0) begin
                p = (i - 1) / 2;
                if (!beats(0, up_h[i], up_h[p])) break;
                t = up_h[i]; up_h[i] = up_h[p]; up_h[p] = t; i = p;
            end
        end
    endtask

    task automatic sift_down(bit is_max);
        int i, l, b, n;
        logic signed [31:0] t;
        i = 0;
        n = is_max ? lo_n : up_n;
        forever begin
            l = 2 * i + 1;
            if (l >= n) break;
            b = l;
            if (is_max) begin
                if (l + 1 < n && beats(1, lo_h[l+1], lo_h[l])) b = l + 1;
                if (!beats(1, lo_h[b], lo_h[i])) break;
                t = lo_h[i]; lo_h[i] = lo_h[b]; lo_h[b] = t;
            end else begin
                if (l + 1 < n && beats(0, up_h[l+1], up_h[l])) b = l + 1;
                if (!beats(0, up_h[b], up_h[i])) break;
                t = up_h[i]; up_h[i] = up_h[b]; up_h[b] = t;
            end
            i = b;
        end
    endtask

    task automatic heap_pop(bit is_max, output logic signed [31:0] top);
        if (is_max) begin
            top = lo_h[0]; lo_n--; lo_h[0] = lo_h[lo_n];
        end else begin
            top = up_h[0]; up_n--; up_h[0] = up_h[up_n];
        end
        sift_down(is_max);
    endtask

    task automatic replace_top(bit is_max, logic signed [31:0] v,
                               output logic signed [31:0] old);
        if (is_max) begin
            old = lo_h[0]; lo_h[0] = v;
        end else begin
            old = up_h[0]; up_h[0] = v;
        end
        sift_down(is_max);
    endtask

    task automatic rebalance();
        logic signed [31:0] m;
        if (lo_n > up_n + 1) begin
            heap_pop(1, m); heap_push(0, m);
        end else if (up_n > lo_n + 1) begin
            heap_pop(0, m); heap_push(1, m);
        end
    endtask

    task automatic insert_sample(logic signed [31:0] x);
        median_t r;
        logic signed [31:0] m;
        r.dropped = 1'b0;
        r.median  = '0;
        if (lo_n + up_n >= 2 * CAP) begin
            r.dropped = 1'b1;
        end else if (lo_n == 0 || x < lo_h[0]) begin
            if (lo_n < CAP) begin
                heap_push(1, x); rebalance();
            end else begin
                replace_top(1, x, m); heap_push(0, m);
            end
        end else begin
            if (up_n < CAP) begin
                heap_push(0, x); rebalance();
            end else if (x < up_h[0]) begin
                heap_push(1, x);
            end else begin
                replace_top(0, x, m); heap_push(1, m);
            end
        end
        if (lo_n + up_n != 0) r.median = (lo_n >= up_n) ? lo_h[0] : up_h[0];
        median_q.push_back(r);
    endtask

    // input transfers
    always @(posedge aclk) begin
        in_fire = aresetn && s_valid && s_ready;
        if (in_fire) insert_sample(s_sample_value);
    end

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_fire) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    s_valid        <= 1'b1;
                    s_sample_value <= sample_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor
    median_t got, want;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got.median  = m_median_value;
            got.dropped = m_dropped;
            if (median_q.size() == 0) begin
                $error("unexpected median transfer: %0d", m_median_value);
                errors++;
            end else begin
                want = median_q.pop_front();
                if (got.median !== want.median) begin
                    $error("median_value: expected %0d, got %0d", want.median, got.median);
                    errors++;
                end
                if (got.dropped !== want.dropped) begin
                    $error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_sample(int kind);
        case (kind)
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed(32'($urandom_range(20))) - 10;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic drain();
        while (sample_q.size() != 0 || s_valid || median_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic run_phase(int idle, int stall, int n, int kind_hi);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n) sample_q.push_back(rand_sample($urandom_range(kind_hi)));
        drain();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes, equal-to-top and duplicate samples
        sample_q.push_back(32'sh8000_0000);
        sample_q.push_back(32'sh7fff_ffff);
        sample_q.push_back(32'sh7fff_ffff);
        sample_q.push_back(32'sh8000_0000);
        sample_q.push_back(0);
        sample_q.push_back(0);
        sample_q.push_back(0);
        sample_q.push_back(-1);
        sample_q.push_back(1);
        sample_q.push_back(32'sh5555_5555);
        sample_q.push_back(32'shaaaa_aaaa);
        sample_q.push_back(-1);
        drain();

        run_phase(0, 0, 500, 3);
        run_phase(51, 0, 300, 3);
        run_phase(0, 51, 300, 3);
        run_phase(38, 38, 300, 3);
        // past capacity: dropped samples with extreme, small and random values
        run_phase(0, 0, 300, 3);
        run_phase(38, 38, 150, 2);
        run_phase(0, 0, 100, 3);

        repeat (100) @(posedge aclk);
        if (errors == 0 && median_q.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb failed");
        $finish;
    end
endmodule

### filelist.f
design/rmh_pkg.sv
design/rmh_datapath.sv
design/rmh_ctrl.sv
design/running_median_two_heaps_core.sv
verif/tb.sv
